// ===== hw/rtl/sorted_sparse_entry_table_unit_defines.svh =====
// Assertion macros shared by the sparse entry table RTL.
`ifndef SORTED_SPARSE_ENTRY_TABLE_UNIT_DEFINES_SVH
`define SORTED_SPARSE_ENTRY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define SSET_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sset check failed");

// Next-cycle implication, checked outside of reset.
`define SSET_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sset check failed");

`endif

// ===== hw/rtl/sset_pkg.sv =====
// Package with the shared types and codes of the sparse entry table.
`timescale 1ns / 1ps
package sset_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WORD_W     = KEY_W + DATA_W;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STATUS_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND  = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_PROBE,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // One finished result handed from the sequencer to the output stage.
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   old_value;
  } result_t;

endpackage

// ===== hw/rtl/sorted_sparse_entry_table_unit.sv =====
// Top level of the sorted sparse entry table.
//
// Holds up to CAPACITY matrix entries sorted by (row, col). Each input word
// carries mode, row, col and value; mode 0 reads an element, mode 1 writes it
// and inserts a new entry when the position is absent. Each input word yields
// exactly one result word with status and old_value.
// Input and output channels use valid/stall; a word moves when valid is high
// and stall is low. in_stall is high while an item is being worked on.
// Work per word: the binary search over N stored entries takes up to
// ceil(log2(N+1)) steps, each one read of the entry memory, whose read data
// is registered, and one compare. A probe then checks the entry at the found
// position, if there is one. A hit ends there; a miss on a write to a table
// that is not full inserts the item, moving each entry above the position up
// (one memory read and one write each) and then writing the new entry.
// Out-of-range items skip the search. The next word is accepted in the cycle
// after the result enters the output register. A finished result waits there
// while out_stall is high, and the next input word is still accepted meanwhile.
// Reset empties the table and clears both size registers, so every item is
// out of range until row_count and column_count are written.
`timescale 1ns / 1ps
`include "sorted_sparse_entry_table_unit_defines.svh"
module sorted_sparse_entry_table_unit
  import sset_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SIZE_W-1:0]           cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [INDEX_W-1:0]          row,
  input  logic [INDEX_W-1:0]          col,
  input  logic signed [DATA_W-1:0]    value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STATUS_W-1:0]         status,
  output logic signed [DATA_W-1:0]    old_value
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic [SIZE_W-1:0] row_count, column_count;
  logic              seq_idle, res_valid, res_take, range_bad, in_take;
  logic              out_valid_next;
  result_t           res;
  logic [CNT_W-1:0]  count;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default:          row_count    <= row_count;
      endcase
    end
  end

  // Input side and bounds check.
  assign in_stall  = !seq_idle;
  assign in_take   = in_valid && !in_stall;
  assign range_bad = ({1'b0, row} >= row_count) || ({1'b0, col} >= column_count);

  sset_seq #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (in_take),
    .start_mode      (mode),
    .start_key       ({row, col}),
    .start_value     (value),
    .start_range_bad (range_bad),
    .idle            (seq_idle),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res),
    .count           (count)
  );

  // Output register, refilled when empty or being drained.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status    <= res.status;
      old_value <= res.old_value;
    end
  end

  // Checks.
  `SSET_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_take, in_stall)
  `SSET_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SSET_ASSERT_NOW(a_error_zero, clk, rst,
    out_valid && (status == ST_RANGE || status == ST_FULL), old_value == '0)
  `SSET_ASSERT_NEXT(a_range_no_insert, clk, rst, in_take && range_bad, $stable(count))

endmodule

// ===== hw/rtl/sset_entry_ram.sv =====
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module sset_entry_ram
  import sset_pkg::*;
#(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [WORD_W-1:0]   wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [WORD_W-1:0]   rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data available in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/sset_seq.sv =====
// Sequencer: binary search, probe, shift and insert over the entry memory.
`timescale 1ns / 1ps
module sset_seq
  import sset_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned ADDR_W   = 8,
  parameter int unsigned CNT_W    = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_mode,
  input  logic [KEY_W-1:0]    start_key,
  input  logic [DATA_W-1:0]   start_value,
  input  logic                start_range_bad,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_take,
  output result_t             res,
  output logic [CNT_W-1:0]    count
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  state_t state, state_next;

  logic               mode;
  logic [KEY_W-1:0]   key;
  logic [DATA_W-1:0]  value;
  logic [CNT_W-1:0]   lo, hi, mid;
  logic [CNT_W-1:0]   shift_idx;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  logic               key_lt, key_eq;
  logic               search_open, probe_ok, shift_more, table_full;

  sset_entry_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Key comparators: key_lt steers the search steps, key_eq decides the probe.
  assign key_lt = mem_rdata[WORD_W-1:DATA_W] < key;
  assign key_eq = mem_rdata[WORD_W-1:DATA_W] == key;

  assign mid         = lo + ((hi - lo) >> 1);
  assign search_open = lo < hi;
  assign probe_ok    = lo < count;
  assign shift_more  = shift_idx > lo;
  assign table_full  = count == CAP;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = start_range_bad ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_open) begin
          state_next = S_COMPARE;
        end else if (probe_ok) begin
          state_next = S_PROBE;
        end else begin
          state_next = S_MISS;
        end
      end
      S_COMPARE:  state_next = S_SEARCH;
      S_PROBE:    state_next = key_eq ? S_DONE : S_MISS;
      S_MISS: begin
        if (!mode || table_full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_next = shift_more ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE:     state_next = res_take ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory strobes and handshake outputs.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = mid[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = lo[ADDR_W-1:0];
    mem_wdata = {key, value};
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state)
      S_IDLE:   idle = 1'b1;
      S_SEARCH: begin
        mem_re    = 1'b1;
        mem_raddr = search_open ? mid[ADDR_W-1:0] : lo[ADDR_W-1:0];
      end
      S_PROBE: begin
        // Overwrite a hit in place on a modify.
        mem_we = key_eq && mode;
      end
      S_SHIFT_RD: begin
        if (shift_more) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(shift_idx - ONE);
        end else begin
          mem_we = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = shift_idx[ADDR_W-1:0];
        mem_wdata = mem_rdata;
      end
      S_DONE:   res_valid = 1'b1;
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // State and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_SHIFT_RD && !shift_more) begin
        count <= count + ONE;
      end
    end
  end

  // Search bounds, shift pointer, captured item and result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          mode          <= start_mode;
          key           <= start_key;
          value         <= start_value;
          lo            <= '0;
          hi            <= count;
          res.status    <= ST_RANGE;
          res.old_value <= '0;
        end
      end
      S_COMPARE: begin
        if (key_lt) begin
          lo <= mid + ONE;
        end else begin
          hi <= mid;
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          res.status    <= ST_FOUND;
          res.old_value <= mem_rdata[DATA_W-1:0];
        end
      end
      S_MISS: begin
        shift_idx     <= count;
        res.old_value <= '0;
        if (mode && table_full) begin
          res.status <= ST_FULL;
        end else begin
          res.status <= ST_ABSENT;
        end
      end
      S_SHIFT_WR: shift_idx <= shift_idx - ONE;
      default: begin
        shift_idx <= shift_idx;
      end
    endcase
  end

endmodule
